// ----- sv/tapqm_pkg.sv -----
// Shared widths, register codes, reset values and item types for the PID mixer.
package tapqm_pkg;

  localparam int ANGLE_W    = 16;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int GAIN_W     = 16;
  localparam int GAINS_W    = 48;
  localparam int PWM_W      = 12;
  localparam int STEP_W     = 16;
  localparam int RATE_W     = 12;
  localparam int DR_W       = 30;
  localparam int INTEG_W    = 48;
  localparam int ACC_W      = 64;
  localparam int AXIS_W     = 32;
  localparam int MIX_W      = 35;
  localparam int MPLR_W     = 16;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_SHIFT  = 8 + FRAC_BITS;

  localparam logic [CNT_W-1:0] MUL16_LAST = CNT_W'(MPLR_W - 1);
  localparam logic [CNT_W-1:0] RATE_LAST  = CNT_W'(RATE_W - 1);

  localparam logic signed [ACC_W-1:0] INTEG_LIM = 64'sh0000_4000_0000_0000;
  localparam logic signed [ACC_W-1:0] AXIS_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] AXIS_MIN  = 64'shFFFF_FFFF_8000_0000;

  localparam logic [GAINS_W-1:0] GAINS_PITCH_RST = 48'h0400_0000_0100;
  localparam logic [GAINS_W-1:0] GAINS_ROLL_RST  = 48'h0400_0000_0100;
  localparam logic [GAINS_W-1:0] GAINS_YAW_RST   = 48'h0000_0000_0000;
  localparam logic [PWM_W-1:0]   THROTTLE_RST    = 12'd1400;
  localparam logic [PWM_W-1:0]   CEILING_RST     = 12'd2000;
  localparam logic [STEP_W-1:0]  STEP_RST        = 16'd262;
  localparam logic [RATE_W-1:0]  RATE_RST        = 12'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAINS_PITCH   = 3'd0,
    REG_GAINS_ROLL    = 3'd1,
    REG_GAINS_YAW     = 3'd2,
    REG_BASE_THROTTLE = 3'd3,
    REG_PWM_CEILING   = 3'd4,
    REG_STEP_TIME     = 3'd5,
    REG_LOOP_RATE     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [STEP_W-1:0] step_time;
    logic [RATE_W-1:0] loop_rate;
  } axis_cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] meas_pitch;
    logic signed [ANGLE_W-1:0] meas_roll;
    logic signed [ANGLE_W-1:0] meas_yaw;
    logic signed [ANGLE_W-1:0] target_pitch;
    logic signed [ANGLE_W-1:0] target_roll;
    logic signed [ANGLE_W-1:0] target_yaw;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0] motor_front_right;
    logic [PWM_W-1:0] motor_rear_right;
    logic [PWM_W-1:0] motor_rear_left;
    logic [PWM_W-1:0] motor_front_left;
  } out_item_t;

endpackage

// ----- sv/tapqm_stream_if.sv -----
// Valid/ready stream interface carrying one payload per request.
interface tapqm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tapqm_axis.sv -----
// One PID axis built around a bit-serial shift-and-add multiplier.
module tapqm_axis #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic signed [tapqm_pkg::ANGLE_W-1:0]       meas,
  input  logic signed [tapqm_pkg::ANGLE_W-1:0]       target,
  input  tapqm_pkg::axis_cfg_t                       cfg,
  output logic                                       done,
  output logic signed [tapqm_pkg::AXIS_W-1:0]        result
);
  import tapqm_pkg::*;

  localparam int SW1 = SUM_WIDTH + 1;

  typedef enum logic [3:0] {
    A_IDLE, A_MUL_ST, A_INTEG, A_MUL_RATE, A_LOAD_KP, A_MUL_KP,
    A_LOAD_KI, A_MUL_KI, A_LOAD_KD, A_MUL_KD, A_FINISH
  } astate_t;

  astate_t                     state_r, state_nxt;
  logic                        done_r, done_nxt;
  logic signed [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic signed [ERR_W-1:0]     last_r, last_nxt;
  logic signed [ERR_W-1:0]     e_r, e_nxt;
  logic signed [INTEG_W-1:0]   integ_r, integ_nxt;
  logic signed [DR_W-1:0]      dr_r, dr_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [ACC_W-1:0]     mcand_r, mcand_nxt;
  logic [MPLR_W-1:0]           mplier_r, mplier_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic signed [AXIS_W-1:0]    result_r, result_nxt;

  logic signed [ERR_W-1:0]     e_in;
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [ACC_W-1:0]     acc_step;
  logic signed [ACC_W-1:0]     iq;
  logic signed [ACC_W-1:0]     iq_clamped;
  logic signed [ACC_W-1:0]     fq;
  logic signed [ACC_W-1:0]     fq_sat;

  assign e_in    = ERR_W'(target) - ERR_W'(meas);
  assign sum_ext = SW1'(sum_r) + SW1'(e_in);
  assign diff    = DIFF_W'(e_r) - DIFF_W'(last_r);
  assign acc_step = mplier_r[0] ? acc_r + mcand_r : acc_r;

  always_comb begin
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_sat = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                   : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    iq = acc_r >>> STEP_W;
    if (acc_r[ACC_W-1] && (|acc_r[STEP_W-1:0])) begin
      iq = iq + ACC_W'(1);
    end
    if (iq > INTEG_LIM) begin
      iq_clamped = INTEG_LIM;
    end else if (iq < -INTEG_LIM) begin
      iq_clamped = -INTEG_LIM;
    end else begin
      iq_clamped = iq;
    end
  end

  always_comb begin
    fq = acc_r >>> OUT_SHIFT;
    if (acc_r[ACC_W-1] && (|acc_r[OUT_SHIFT-1:0])) begin
      fq = fq + ACC_W'(1);
    end
    if (fq > AXIS_MAX) begin
      fq_sat = AXIS_MAX;
    end else if (fq < AXIS_MIN) begin
      fq_sat = AXIS_MIN;
    end else begin
      fq_sat = fq;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = 1'b0;
    sum_nxt    = sum_r;
    last_nxt   = last_r;
    e_nxt      = e_r;
    integ_nxt  = integ_r;
    dr_nxt     = dr_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    result_nxt = result_r;
    case (state_r)
      A_IDLE: begin
        if (start) begin
          e_nxt      = e_in;
          sum_nxt    = sum_sat;
          mcand_nxt  = ACC_W'(sum_sat);
          mplier_nxt = cfg.step_time;
          acc_nxt    = '0;
          cnt_nxt    = MUL16_LAST;
          state_nxt  = A_MUL_ST;
        end
      end
      A_MUL_ST, A_MUL_RATE, A_MUL_KP, A_MUL_KI, A_MUL_KD: begin
        acc_nxt    = acc_step;
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          case (state_r)
            A_MUL_ST:   state_nxt = A_INTEG;
            A_MUL_RATE: state_nxt = A_LOAD_KP;
            A_MUL_KP:   state_nxt = A_LOAD_KI;
            A_MUL_KI:   state_nxt = A_LOAD_KD;
            default:    state_nxt = A_FINISH;
          endcase
        end
      end
      A_INTEG: begin
        integ_nxt  = iq_clamped[INTEG_W-1:0];
        mcand_nxt  = ACC_W'(diff);
        mplier_nxt = MPLR_W'(cfg.loop_rate);
        acc_nxt    = '0;
        cnt_nxt    = RATE_LAST;
        last_nxt   = e_r;
        state_nxt  = A_MUL_RATE;
      end
      A_LOAD_KP: begin
        dr_nxt     = acc_r[DR_W-1:0];
        mcand_nxt  = ACC_W'(e_r);
        mplier_nxt = cfg.kp;
        acc_nxt    = '0;
        cnt_nxt    = MUL16_LAST;
        state_nxt  = A_MUL_KP;
      end
      A_LOAD_KI: begin
        mcand_nxt  = ACC_W'(integ_r);
        mplier_nxt = cfg.ki;
        cnt_nxt    = MUL16_LAST;
        state_nxt  = A_MUL_KI;
      end
      A_LOAD_KD: begin
        mcand_nxt  = ACC_W'(dr_r);
        mplier_nxt = cfg.kd;
        cnt_nxt    = MUL16_LAST;
        state_nxt  = A_MUL_KD;
      end
      A_FINISH: begin
        result_nxt = fq_sat[AXIS_W-1:0];
        done_nxt   = 1'b1;
        state_nxt  = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      sum_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      sum_r    <= sum_nxt;
      last_r   <= last_nxt;
      e_r      <= e_nxt;
      integ_r  <= integ_nxt;
      dr_r     <= dr_nxt;
      acc_r    <= acc_nxt;
      mcand_r  <= mcand_nxt;
      mplier_r <= mplier_nxt;
      cnt_r    <= cnt_nxt;
      result_r <= result_nxt;
    end
  end

  assign done   = done_r;
  assign result = result_r;

  a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == A_IDLE)
    else $error("axis started while busy");

  a_done_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("axis done held for more than one cycle");

  a_integ_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == A_MUL_RATE |-> (integ_r <= INTEG_LIM) && (integ_r >= -INTEG_LIM))
    else $error("integral term outside its clamp");

endmodule

// ----- sv/three_axis_pid_quad_mixer.sv -----
// Top level: three-axis PID controller with X-frame quad motor mixer.
//
//   Channel  Direction  Handshake              Payload
//   in_chan  sink       in_chan.valid/ready    measured and target angles, Q8.8
//   out_chan source     out_chan.valid/ready   four clamped motor PWM values
//   cfg_*    write      cfg_we                 cfg_index selects, cfg_data holds
//
// The run time of a request is set by the bit-serial multiplier in each axis: five
// products of 16, 12, 16, 16 and 16 multiplier bits plus load and finish steps.
// The three axes run side by side; a mix step then loads the output register.
// A new request is taken while an earlier result still waits on out_chan.
// Reset is synchronous and active low; it restores the registers and clears the
// integrators and stored errors. A stalled output holds the block in its mix step.
module three_axis_pid_quad_mixer #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tapqm_stream_if.sink                         in_chan,
  tapqm_stream_if.source                       out_chan,
  input  logic                                 cfg_we,
  input  logic [tapqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tapqm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tapqm_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_MIX} tstate_t;

  tstate_t          state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [GAINS_W-1:0] gains_pitch_r, gains_roll_r, gains_yaw_r;
  logic [PWM_W-1:0]   base_throttle_r, pwm_ceiling_r;
  logic [STEP_W-1:0]  step_time_r;
  logic [RATE_W-1:0]  loop_rate_r;

  axis_cfg_t                cfg_pitch, cfg_roll, cfg_yaw;
  logic                     start;
  logic [2:0]               done;
  logic signed [AXIS_W-1:0] p_out, r_out, y_out;
  logic signed [MIX_W-1:0]  t_s, p_s, r_s, y_s;
  out_item_t                mixed;

  function automatic logic [PWM_W-1:0] clamp_motor(
    input logic signed [MIX_W-1:0] m,
    input logic [PWM_W-1:0]        lo,
    input logic [PWM_W-1:0]        hi
  );
    logic signed [MIX_W-1:0] lo_s;
    logic signed [MIX_W-1:0] hi_s;
    logic [PWM_W-1:0]        res;
    lo_s = MIX_W'(lo);
    hi_s = MIX_W'(hi);
    if (m < lo_s) begin
      res = lo;
    end else if (m > hi_s) begin
      res = hi;
    end else begin
      res = m[PWM_W-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_pitch_r   <= GAINS_PITCH_RST;
      gains_roll_r    <= GAINS_ROLL_RST;
      gains_yaw_r     <= GAINS_YAW_RST;
      base_throttle_r <= THROTTLE_RST;
      pwm_ceiling_r   <= CEILING_RST;
      step_time_r     <= STEP_RST;
      loop_rate_r     <= RATE_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GAINS_PITCH:   gains_pitch_r   <= cfg_data[GAINS_W-1:0];
        REG_GAINS_ROLL:    gains_roll_r    <= cfg_data[GAINS_W-1:0];
        REG_GAINS_YAW:     gains_yaw_r     <= cfg_data[GAINS_W-1:0];
        REG_BASE_THROTTLE: base_throttle_r <= cfg_data[PWM_W-1:0];
        REG_PWM_CEILING:   pwm_ceiling_r   <= cfg_data[PWM_W-1:0];
        REG_STEP_TIME:     step_time_r     <= cfg_data[STEP_W-1:0];
        REG_LOOP_RATE:     loop_rate_r     <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_pitch = '{kp: gains_pitch_r[47:32], ki: gains_pitch_r[31:16],
                       kd: gains_pitch_r[15:0], step_time: step_time_r,
                       loop_rate: loop_rate_r};
  assign cfg_roll  = '{kp: gains_roll_r[47:32], ki: gains_roll_r[31:16],
                       kd: gains_roll_r[15:0], step_time: step_time_r,
                       loop_rate: loop_rate_r};
  assign cfg_yaw   = '{kp: gains_yaw_r[47:32], ki: gains_yaw_r[31:16],
                       kd: gains_yaw_r[15:0], step_time: step_time_r,
                       loop_rate: loop_rate_r};

  assign in_chan.ready = (state_r == T_IDLE);
  assign start         = in_chan.valid && (state_r == T_IDLE);

  tapqm_axis #(.SUM_WIDTH(SUM_WIDTH)) u_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .meas   (in_chan.data.meas_pitch),
    .target (in_chan.data.target_pitch),
    .cfg    (cfg_pitch),
    .done   (done[0]),
    .result (p_out)
  );

  tapqm_axis #(.SUM_WIDTH(SUM_WIDTH)) u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .meas   (in_chan.data.meas_roll),
    .target (in_chan.data.target_roll),
    .cfg    (cfg_roll),
    .done   (done[1]),
    .result (r_out)
  );

  tapqm_axis #(.SUM_WIDTH(SUM_WIDTH)) u_yaw (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .meas   (in_chan.data.meas_yaw),
    .target (in_chan.data.target_yaw),
    .cfg    (cfg_yaw),
    .done   (done[2]),
    .result (y_out)
  );

  always_comb begin
    t_s = MIX_W'(base_throttle_r);
    p_s = MIX_W'(p_out);
    r_s = MIX_W'(r_out);
    y_s = MIX_W'(y_out);
    mixed.motor_front_right = clamp_motor(t_s - p_s + r_s - y_s,
                                          base_throttle_r, pwm_ceiling_r);
    mixed.motor_rear_right  = clamp_motor(t_s + p_s + r_s + y_s,
                                          base_throttle_r, pwm_ceiling_r);
    mixed.motor_rear_left   = clamp_motor(t_s + p_s - r_s - y_s,
                                          base_throttle_r, pwm_ceiling_r);
    mixed.motor_front_left  = clamp_motor(t_s - p_s - r_s + y_s,
                                          base_throttle_r, pwm_ceiling_r);
  end

  always_comb begin
    state_nxt     = state_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      T_IDLE: begin
        if (start) begin
          state_nxt = T_RUN;
        end
      end
      T_RUN: begin
        if (done[0]) begin
          state_nxt = T_MIX;
        end
      end
      T_MIX: begin
        if (!out_valid_r || out_chan.ready) begin
          out_data_nxt  = mixed;
          out_valid_nxt = 1'b1;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  a_axes_in_step : assert property (@(posedge clk) disable iff (!rst_n)
    (done[0] == done[1]) && (done[1] == done[2]))
    else $error("axes finished in different cycles");

  a_load_from_mix : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_MIX))
    else $error("result shown without a mix step");

  a_motor_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_data_r.motor_front_right == base_throttle_r) ||
       (out_data_r.motor_front_right <= pwm_ceiling_r)) &&
      ((out_data_r.motor_rear_right == base_throttle_r) ||
       (out_data_r.motor_rear_right <= pwm_ceiling_r)) &&
      ((out_data_r.motor_rear_left == base_throttle_r) ||
       (out_data_r.motor_rear_left <= pwm_ceiling_r)) &&
      ((out_data_r.motor_front_left == base_throttle_r) ||
       (out_data_r.motor_front_left <= pwm_ceiling_r)))
    else $error("motor value outside its clamp");

endmodule

// ----- dv/tapqm_motor_checker.sv -----
// Watches the PID mixer channels, predicts every motor request and counts disagreements.
module tapqm_motor_checker #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  tapqm_pkg::in_item_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  tapqm_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [tapqm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tapqm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               outstanding,
  output int                               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tapqm_pkg::*;

  logic [GAINS_W-1:0] gains[3];
  logic [PWM_W-1:0]   throttle;
  logic [PWM_W-1:0]   ceiling;
  logic [STEP_W-1:0]  step_dt;
  logic [RATE_W-1:0]  rate_hz;
  longint             err_sum[3];
  longint             prev_err[3];
  out_item_t          motor_cmds_due[$];
  int                 fails;
  int                 results_seen;

  function automatic longint sx(logic signed [ANGLE_W-1:0] v);
    return v;
  endfunction

  function automatic longint axis_effort(int a, longint e);
    longint kp, ki, kd, smax, smin, acc, integ, num, eff;
    kp = {48'd0, gains[a][47:32]};
    ki = {48'd0, gains[a][31:16]};
    kd = {48'd0, gains[a][15:0]};
    smax = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    smin = -smax - 1;
    acc = err_sum[a] + e;
    if (acc > smax) acc = smax;
    if (acc < smin) acc = smin;
    err_sum[a] = acc;
    integ = (acc * longint'({48'd0, step_dt})) / 64'sd65536;
    if (integ > INTEG_LIM) integ = INTEG_LIM;
    if (integ < -INTEG_LIM) integ = -INTEG_LIM;
    num = kp * e + ki * integ + kd * (e - prev_err[a]) * longint'({52'd0, rate_hz});
    eff = num / (longint'(1) << OUT_SHIFT);
    if (eff > AXIS_MAX) eff = AXIS_MAX;
    if (eff < AXIS_MIN) eff = AXIS_MIN;
    prev_err[a] = e;
    return eff;
  endfunction

  // Below the throttle wins first, so a ceiling under the throttle only caps
  // values at or above the throttle.
  function automatic logic [PWM_W-1:0] clamp_pwm(longint m);
    longint lo, hi;
    lo = {52'd0, throttle};
    hi = {52'd0, ceiling};
    if (m < lo) m = lo;
    else if (m > hi) m = hi;
    return m[PWM_W-1:0];
  endfunction

  function automatic out_item_t predict_motors(in_item_t d);
    longint    err[3];
    longint    eff[3];
    longint    t;
    out_item_t m;
    err[0] = sx(d.target_pitch) - sx(d.meas_pitch);
    err[1] = sx(d.target_roll) - sx(d.meas_roll);
    err[2] = sx(d.target_yaw) - sx(d.meas_yaw);
    for (int a = 0; a < 3; a++) eff[a] = axis_effort(a, err[a]);
    t = {52'd0, throttle};
    m.motor_front_right = clamp_pwm(t - eff[0] + eff[1] - eff[2]);
    m.motor_rear_right  = clamp_pwm(t + eff[0] + eff[1] + eff[2]);
    m.motor_rear_left   = clamp_pwm(t + eff[0] - eff[1] - eff[2]);
    m.motor_front_left  = clamp_pwm(t - eff[0] - eff[1] + eff[2]);
    return m;
  endfunction

  task automatic flag_mismatch(input string what);
    fails++;
    if (fails <= 10) $display("[%0t ns] motor check: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      gains[0] = GAINS_PITCH_RST;
      gains[1] = GAINS_ROLL_RST;
      gains[2] = GAINS_YAW_RST;
      throttle = THROTTLE_RST;
      ceiling = CEILING_RST;
      step_dt = STEP_RST;
      rate_hz = RATE_RST;
      for (int a = 0; a < 3; a++) begin
        err_sum[a] = 0;
        prev_err[a] = 0;
      end
      motor_cmds_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAINS_PITCH:   gains[0] = cfg_data[GAINS_W-1:0];
          REG_GAINS_ROLL:    gains[1] = cfg_data[GAINS_W-1:0];
          REG_GAINS_YAW:     gains[2] = cfg_data[GAINS_W-1:0];
          REG_BASE_THROTTLE: throttle = cfg_data[PWM_W-1:0];
          REG_PWM_CEILING:   ceiling = cfg_data[PWM_W-1:0];
          REG_STEP_TIME:     step_dt = cfg_data[STEP_W-1:0];
          REG_LOOP_RATE:     rate_hz = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (motor_cmds_due.size() == 0) begin
          flag_mismatch($sformatf(
            "result %0d arrived with nothing expected: fr/rr/rl/fl %0d/%0d/%0d/%0d",
            results_seen, out_data.motor_front_right, out_data.motor_rear_right,
            out_data.motor_rear_left, out_data.motor_front_left));
        end else begin
          want = motor_cmds_due.pop_front();
          bad = 1'b0;
          for (int k = 0; k < 4; k++)
            if (out_data[k*PWM_W +: PWM_W] !== want[k*PWM_W +: PWM_W]) bad = 1'b1;
          if (bad)
            flag_mismatch($sformatf(
              "result %0d fr/rr/rl/fl expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
              results_seen, want.motor_front_right, want.motor_rear_right,
              want.motor_rear_left, want.motor_front_left, out_data.motor_front_right,
              out_data.motor_rear_right, out_data.motor_rear_left, out_data.motor_front_left));
        end
      end
      if (in_valid && in_ready) motor_cmds_due.push_back(predict_motors(in_data));
    end
    outstanding <= motor_cmds_due.size();
    fail_count <= fails;
  end

endmodule

// ----- dv/tb_three_axis_pid_quad_mixer.sv -----
// Testbench top for the PID mixer: clock, reset, register phases, request stimulus, verdict.
module tb_three_axis_pid_quad_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import tapqm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int                   RAND_PHASES = 6;
  localparam int                   PHASE_REQUESTS = 122;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    outstanding;
  int                    fail_count;
  bit                    quiet;
  int                    requests;
  int                    settings;
  in_item_t              attitude;

  tapqm_stream_if #(.payload_t(in_item_t))  in_if ();
  tapqm_stream_if #(.payload_t(out_item_t)) out_if ();

  three_axis_pid_quad_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tapqm_motor_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_data     (in_if.data),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_data    (out_if.data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: ready in random stalls, steady once the run goes quiet.
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic in_item_t attitude_of(int mp, int mr, int my, int tp, int tr, int ty);
    in_item_t d;
    d.meas_pitch = 16'(mp);
    d.meas_roll = 16'(mr);
    d.meas_yaw = 16'(my);
    d.target_pitch = 16'(tp);
    d.target_roll = 16'(tr);
    d.target_yaw = 16'(ty);
    return d;
  endfunction

  function automatic logic [ANGLE_W-1:0] nudge(logic [ANGLE_W-1:0] v);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'(int'(v) + int'($urandom_range(0, 511)) - 256);
    if (sel < 9) return 16'(int'($urandom_range(0, 7680)) - 3840);
    return 16'($urandom);
  endfunction

  function automatic logic [GAINS_W-1:0] pick_gains();
    logic [GAIN_W-1:0] kp, ki, kd;
    kp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0600));
    ki = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0800));
    kd = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0100));
    return {kp, ki, kd};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Narrow registers get random upper bits, which the block must drop.
  task automatic program_regs(input logic [GAINS_W-1:0] gp, input logic [GAINS_W-1:0] gr,
                              input logic [GAINS_W-1:0] gy, input logic [PWM_W-1:0] thr,
                              input logic [PWM_W-1:0] ceil, input logic [STEP_W-1:0] dt,
                              input logic [RATE_W-1:0] rate);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_SPARE, junk);
    write_reg(REG_GAINS_PITCH, gp);
    write_reg(REG_GAINS_ROLL, gr);
    write_reg(REG_GAINS_YAW, gy);
    write_reg(REG_BASE_THROTTLE, {junk[47:12], thr});
    write_reg(REG_PWM_CEILING, {junk[35:0], ceil});
    write_reg(REG_STEP_TIME, {junk[47:16], dt});
    write_reg(REG_LOOP_RATE, {junk[40:5], rate});
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_request(input in_item_t item);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    requests++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [PWM_W-1:0]  thr, ceil;
    logic [STEP_W-1:0] dt;
    logic [RATE_W-1:0] rate;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    attitude = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero, full-scale errors of both signs, small offsets.
    send_request(attitude_of(0, 0, 0, 0, 0, 0));
    send_request(attitude_of(-32768, -32768, -32768, 32767, 32767, 32767));
    send_request(attitude_of(32767, 32767, 32767, -32768, -32768, -32768));
    send_request(attitude_of(32767, -32768, 0, -32768, 32767, 0));
    send_request(attitude_of(256, -256, 1, 0, 0, -1));
    send_request(attitude_of(-1, -1, -1, -1, -1, -1));
    drain();

    // Every gain at its maximum, widest motor window, longest step, a loop rate of 4000.
    program_regs('1, '1, '1, 12'd0, 12'd4095, 16'hFFFF, 12'd4000);
    send_request(attitude_of(-32768, -32768, -32768, 32767, 32767, 32767));
    send_request(attitude_of(-32768, -32768, -32768, 32767, 32767, 32767));
    send_request(attitude_of(32767, 32767, 32767, -32768, -32768, -32768));
    send_request(attitude_of(-32768, 32767, -32768, 32767, -32768, 32767));
    send_request(attitude_of(0, 0, 0, 0, 0, 0));
    drain();

    // No derivative, no integral, and a ceiling beneath the throttle.
    program_regs(48'h0400_0000_0000, 48'h0200_0000_0100, 48'h0100_0000_0000,
                 12'd2000, 12'd1000, 16'd0, 12'd0);
    send_request(attitude_of(0, 0, 0, 2560, 0, 0));
    send_request(attitude_of(0, 0, 0, -2560, 1280, 0));
    send_request(attitude_of(0, 0, 0, 0, 0, 7680));
    send_request(attitude_of(1000, -900, 300, -1000, 900, -300));
    drain();

    // Integral only, so the accumulated error drives the motors.
    program_regs(48'h0000_FFFF_0000, 48'h0000_0100_0000, 48'h0000_8000_0000,
                 12'd2048, 12'd4095, 16'hFFFF, 12'd0);
    send_request(attitude_of(-32768, 0, 100, 32767, 0, -100));
    send_request(attitude_of(-32768, 25600, 100, 32767, 0, -100));
    send_request(attitude_of(32767, -32768, -5, -32768, 32767, 5));
    send_request(attitude_of(12, -12, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      thr = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(800, 1600));
      ceil = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1800, 4095));
      dt = ($urandom_range(0, 2) == 0) ? 16'($urandom) : STEP_RST;
      rate = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(1, 4000)) : RATE_RST;
      if (ph == RAND_PHASES - 1) begin
        thr = THROTTLE_RST;
        ceil = CEILING_RST;
      end
      program_regs(pick_gains(), pick_gains(), pick_gains(), thr, ceil, dt, rate);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (ph == RAND_PHASES - 1 && n == PHASE_REQUESTS / 2) quiet = 1'b1;
        attitude.meas_pitch = nudge(attitude.meas_pitch);
        attitude.meas_roll = nudge(attitude.meas_roll);
        attitude.meas_yaw = nudge(attitude.meas_yaw);
        attitude.target_pitch = nudge(attitude.target_pitch);
        attitude.target_roll = nudge(attitude.target_roll);
        attitude.target_yaw = nudge(attitude.target_yaw);
        send_request(attitude);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d attitude requests over %0d register settings, with input gaps",
             requests, settings);
    $display("and output stalls of up to 16 cycles and a final stretch at full rate.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d motor results disagreed with the prediction.", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tapqm_pkg.sv
sv/tapqm_stream_if.sv
sv/tapqm_axis.sv
sv/three_axis_pid_quad_mixer.sv
dv/tapqm_motor_checker.sv
dv/tb_three_axis_pid_quad_mixer.sv
